// ===== rtl/core/cevq_pkg.sv =====
// types, constants and helpers of the coalescing event queue
// no dependencies
`default_nettype none

package cevq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int ID_W = 16;
  localparam int VOL_W = 8;

  typedef enum logic {
    ACT_POST = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_MERGED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    action_t          action;
    logic [ID_W-1:0]  sound_id;
    logic [VOL_W-1:0] volume;
  } cevq_req_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  out_sound_id;
    logic [VOL_W-1:0] out_volume;
  } cevq_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] vol;
  } cevq_entry_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/coalescing_event_queue.sv =====
// coalescing event queue of sound requests: ring buffer in one synchronous memory
// depends on cevq_pkg
`default_nettype none

// A request either posts a sound (action post) or pops the oldest pending one.
// A post scans the pending entries from head to tail, one memory read per
// cycle, and merges into the first entry with the same sound id, keeping the
// larger volume; without a match it is appended, or dropped when QUEUE_DEPTH-1
// entries are pending. The response of a post is loaded once the scan ends
// at a match or at the tail, and a post to an empty queue is appended without
// a scan; a pop reads the head entry in S_POP and then loads it, and a pop of
// an empty queue goes straight to the result with status empty. The next request
// is taken only after the response is loaded and the block is idle again.
// The scan is serial since the entry memory has a single read port. One request
// is in work at a time; the response register holds a finished response while
// the next request is accepted, and a finished response waits for that
// register to drain when the receiver stalls.
module coalescing_event_queue
  import cevq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  cevq_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output cevq_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_POP,
    S_RESULT
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] p;
  cevq_req_t        req_q;
  cevq_rsp_t        res;

  cevq_entry_t      mem [QUEUE_DEPTH];
  cevq_entry_t      rd_data;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  cevq_entry_t      mem_wdata;
  logic [PTR_W-1:0] mem_raddr;

  logic             accept;
  logic             empty;
  logic             full;
  logic             hit;
  logic             last;
  logic [PTR_W-1:0] p_next;
  logic             rsp_load;

  assign req_ready = (state == S_IDLE) && !rst;
  assign accept    = req_valid && req_ready;
  assign empty     = (rd_ptr == wr_ptr);
  assign full      = (ptr_next(wr_ptr) == rd_ptr);
  assign p_next    = ptr_next(p);
  assign hit       = (rd_data.id == req_q.sound_id);
  assign last      = (p_next == wr_ptr);
  assign rsp_load  = (state == S_RESULT) && (!rsp_valid || rsp_ready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr;
    mem_wdata = '{id: req_q.sound_id, vol: req_q.volume};
    mem_raddr = (state == S_IDLE) ? rd_ptr : p_next;
    case (state)
      S_IDLE: begin
        if (accept && req.action == ACT_POST && empty) begin
          mem_we    = 1'b1;
          mem_wdata = '{id: req.sound_id, vol: req.volume};
        end
      end
      S_SEARCH: begin
        if (hit) begin
          mem_we    = (req_q.volume > rd_data.vol);
          mem_waddr = p;
        end else if (last && !full) begin
          mem_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= req;
            p     <= rd_ptr;
            res   <= '{status: (req.action == ACT_POP && empty) ? ST_EMPTY : ST_QUEUED,
                       out_sound_id: '0, out_volume: '0};
            if (req.action == ACT_POST) begin
              if (empty) begin
                wr_ptr <= ptr_next(wr_ptr);
                state  <= S_RESULT;
              end else begin
                state <= S_SEARCH;
              end
            end else begin
              if (empty) begin
                state <= S_RESULT;
              end else begin
                state <= S_POP;
              end
            end
          end
        end
        S_SEARCH: begin
          p <= p_next;
          if (hit) begin
            res.status <= ST_MERGED;
            state      <= S_RESULT;
          end else if (last) begin
            if (full) begin
              res.status <= ST_DROPPED;
            end else begin
              res.status <= ST_QUEUED;
              wr_ptr     <= ptr_next(wr_ptr);
            end
            state <= S_RESULT;
          end
        end
        S_POP: begin
          res    <= '{status: ST_POPPED, out_sound_id: rd_data.id, out_volume: rd_data.vol};
          rd_ptr <= ptr_next(rd_ptr);
          state  <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_load) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search never runs past the tail
  assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> p != wr_ptr)
    else $error("search pointer reached tail");

  // an accepted request always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted request not taken into work");

  // a pop of a pending entry advances the head
  assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> rd_ptr != $past(rd_ptr))
    else $error("pop did not advance head");

  // only pops carry payload
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_POPPED |-> rsp.out_sound_id == '0 && rsp.out_volume == '0)
    else $error("non-pop response carries payload");

  // the memory is written only on a post
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SEARCH || (state == S_IDLE && accept && req.action == ACT_POST)))
    else $error("memory write outside a post");

endmodule

`default_nettype wire
